### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, muted while in reset.
`define SLMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge.
`define SLMD_NEVER(lbl, cond, msg) \
	`SLMD_ASSERT(lbl, !(cond), msg)

`endif

### rtl/slmd_pkg.sv
`timescale 1ns / 1ps

package slmd_pkg;

	localparam int S_DATA_W = 72;
	localparam int S_USER_W = 1;
	localparam int M_DATA_W = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MARKER_BITS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAVE_FRAME_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ELAPSED_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TRAVEL_MM     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN_FRAMES    = 3'd4;

	// Request kinds carried in tuser
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_START  = 1'b1;

	localparam logic [7:0] RUN_MAX = 8'hFF;

	// Result item, last field in the lowest bits
	typedef struct packed {
		logic [31:0] center_mm;
		logic        stop_hit;
		logic [7:0]  run_frames;
		logic        candidate;
		logic        left_start;
		logic [3:0]  echo_bits;
	} out_item_t;

	function automatic logic [2:0] popcount4(input logic [3:0] v);
		popcount4 = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
	endfunction

endpackage

### rtl/stop_line_marker_detector_core.sv
`timescale 1ns / 1ps

// Stop line marker detector. Start events (tuser = 1) arm the detector; sensor
// samples (tuser = 0) each return one result transfer, start events return none.
// One item is accepted per clock cycle; a sample's result passes the input register,
// then the result register, before it is offered on the master side, and the
// combinational state update between those registers sets this rate. Backpressure
// on the master side stalls only samples; a start event passes the input register
// without needing a result slot. Configuration is written through the cfg channel,
// which is always ready, and must only change while no item is in flight.

`include "assert_macros.svh"

module stop_line_marker_detector_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [3:0] sensor_bits, [35:4] travel_mm, [67:36] time_ms, [71:68] zero
	input  logic [slmd_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// [0] req_type
	input  logic [slmd_pkg::S_USER_W-1:0]    s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [3:0] echo_bits, [4] left_start, [5] candidate, [13:6] run_frames,
	// [14] stop flag, [46:15] center_mm, [47] zero
	output logic [slmd_pkg::M_DATA_W-1:0]    m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [slmd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import slmd_pkg::*;

	// configuration
	logic [2:0]  min_marker_bits_q;
	logic [7:0]  leave_frame_limit_q;
	logic [31:0] min_elapsed_ms_q;
	logic [31:0] min_travel_mm_q;
	logic [7:0]  min_run_frames_q;

	// detector state
	logic        armed_q, has_left_q, inside_run_q;
	logic [7:0]  clear_count_q, run_count_q;
	logic [31:0] start_time_q, run_first_mm_q, run_last_mm_q;

	logic        armed_n, has_left_n, inside_run_n;
	logic [7:0]  clear_count_n, run_count_n;
	logic [31:0] start_time_n, run_first_mm_n, run_last_mm_n;

	// input register
	logic        valid_s1;
	logic        req_type_s1;
	logic [3:0]  sensor_bits_s1;
	logic [31:0] travel_mm_s1, time_ms_s1;

	// result register
	logic        valid_s2;
	out_item_t   item_s2;
	out_item_t   item_n;

	logic        out_free, adv_s1, s_take;
	logic        marker, gate_closed;
	logic [7:0]  clear_inc;
	logic [31:0] elapsed, run_span;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_marker_bits_q   <= 3'd3;
			leave_frame_limit_q <= 8'd5;
			min_elapsed_ms_q    <= 32'd1000;
			min_travel_mm_q     <= 32'd500;
			min_run_frames_q    <= 8'd3;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_MARKER_BITS:   min_marker_bits_q   <= cfg_data[2:0];
				REG_LEAVE_FRAME_LIMIT: leave_frame_limit_q <= cfg_data[7:0];
				REG_MIN_ELAPSED_MS:    min_elapsed_ms_q    <= cfg_data;
				REG_MIN_TRAVEL_MM:     min_travel_mm_q     <= cfg_data;
				REG_MIN_RUN_FRAMES:    min_run_frames_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Handshake: a start event leaves s1 without a result slot
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && (req_type_s1 == REQ_START || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign s_take        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			req_type_s1    <= s_axis_tuser[0];
			sensor_bits_s1 <= s_axis_tdata[3:0];
			travel_mm_s1   <= s_axis_tdata[35:4];
			time_ms_s1     <= s_axis_tdata[67:36];
		end
	end

	assign marker      = popcount4(sensor_bits_s1) >= min_marker_bits_q;
	assign clear_inc   = clear_count_q + 8'd1;
	assign elapsed     = time_ms_s1 - start_time_q;
	assign gate_closed = (elapsed < min_elapsed_ms_q) || (travel_mm_s1 < min_travel_mm_q);
	assign run_span    = run_last_mm_q - run_first_mm_q;

	always_comb begin
		armed_n        = armed_q;
		has_left_n     = has_left_q;
		inside_run_n   = inside_run_q;
		clear_count_n  = clear_count_q;
		run_count_n    = run_count_q;
		start_time_n   = start_time_q;
		run_first_mm_n = run_first_mm_q;
		run_last_mm_n  = run_last_mm_q;

		item_n            = '0;
		item_n.echo_bits  = sensor_bits_s1;
		item_n.left_start = has_left_q;

		if (req_type_s1 == REQ_START) begin
			armed_n        = 1'b1;
			has_left_n     = 1'b0;
			inside_run_n   = 1'b0;
			clear_count_n  = '0;
			run_count_n    = '0;
			start_time_n   = time_ms_s1;
			run_first_mm_n = travel_mm_s1;
			run_last_mm_n  = travel_mm_s1;
		end else if (armed_q) begin
			if (!has_left_q) begin
				if (marker) begin
					clear_count_n = '0;
				end else begin
					clear_count_n = clear_inc;
					if (clear_inc >= leave_frame_limit_q) begin
						has_left_n = 1'b1;
					end
				end
				item_n.left_start = has_left_n;
			end else if (!gate_closed) begin
				if (marker) begin
					inside_run_n = 1'b1;
					if (!inside_run_q) begin
						run_count_n    = 8'd1;
						run_first_mm_n = travel_mm_s1;
					end else if (run_count_q < RUN_MAX) begin
						run_count_n = run_count_q + 8'd1;
					end
					run_last_mm_n     = travel_mm_s1;
					item_n.candidate  = 1'b1;
					item_n.run_frames = run_count_n;
				end else if (inside_run_q) begin
					if (run_count_q >= min_run_frames_q) begin
						item_n.stop_hit  = 1'b1;
						item_n.center_mm = run_first_mm_q + {1'b0, run_span[31:1]};
					end
					inside_run_n = 1'b0;
					run_count_n  = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q        <= 1'b0;
			has_left_q     <= 1'b0;
			inside_run_q   <= 1'b0;
			clear_count_q  <= '0;
			run_count_q    <= '0;
			start_time_q   <= '0;
			run_first_mm_q <= '0;
			run_last_mm_q  <= '0;
		end else if (adv_s1) begin
			armed_q        <= armed_n;
			has_left_q     <= has_left_n;
			inside_run_q   <= inside_run_n;
			clear_count_q  <= clear_count_n;
			run_count_q    <= run_count_n;
			start_time_q   <= start_time_n;
			run_first_mm_q <= run_first_mm_n;
			run_last_mm_q  <= run_last_mm_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && req_type_s1 == REQ_SAMPLE) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_type_s1 == REQ_SAMPLE) begin
			item_s2 <= item_n;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, item_s2};

	`SLMD_NEVER(a_stop_not_candidate, valid_s2 && item_s2.stop_hit && item_s2.candidate, "stop event reported inside a run")
	`SLMD_NEVER(a_candidate_counts, valid_s2 && item_s2.candidate && item_s2.run_frames == 8'd0, "candidate with zero run length")
	`SLMD_ASSERT(a_run_needs_departure, inside_run_q |-> (armed_q && has_left_q && run_count_q != 8'd0), "run open before departure")
	`SLMD_ASSERT(a_center_only_on_stop, (valid_s2 && !item_s2.stop_hit) |-> item_s2.center_mm == 32'd0, "center without stop event")

endmodule
